// File: hw/rtl/u2u_pkg.sv
// Shared types, constants and codes of the UTF-8 to UTF-16 stream transcoder.
package u2u_pkg;

	// Default for the longest string the needed-bytes count is sized for
	localparam int unsigned MAX_STR_BYTES_DEF = 65536;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 2'd1;

	localparam int unsigned CAP_W  = 17;
	localparam int unsigned NEED_W = 18;
	localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

	// Status codes reported with the end of a string
	localparam logic [1:0] ST_SUCCESS    = 2'd0;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW   = 2'd2;

	// Code point constants
	localparam logic [20:0] CP_REPL    = 21'h00FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] CP_BMP_MAX = 21'h00FFFF;
	localparam logic [20:0] CP_SUPP    = 21'h010000;
	localparam logic [15:0] SURR_HI    = 16'hD800;
	localparam logic [15:0] SURR_LO    = 16'hDC00;

	// Most result beats one source byte can cause
	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic [15:0]       unit_value;
		logic              unit_valid;
		logic              run_end;
		logic [1:0]        status;
		logic [NEED_W-1:0] needed_bytes;
	} out_beat_t;

	// Per-string control state
	typedef struct packed {
		logic [1:0]        pend_cnt;
		logic [2:0]        exp_len;
		logic [CAP_W-1:0]  units_left;
		logic [NEED_W-1:0] needed;
		logic              not_mapped;
		logic              overflow;
	} str_state_t;

	// Results of one source byte, in order, with their count
	typedef struct packed {
		out_beat_t [MAX_RES-1:0] res;
		logic [2:0]              cnt;
	} res_group_t;

endpackage

// File: hw/rtl/u2u_decode.sv
// Single-pass decode of one source byte: next string state and its result beats.
module u2u_decode import u2u_pkg::*; #(
	parameter int unsigned MAX_STRING_BYTES = MAX_STR_BYTES_DEF
) (
	input  in_beat_t         beat,
	input  str_state_t       st,
	input  logic [2:0][7:0]  pend,
	input  logic             count_only,
	input  logic [CAP_W-1:0] capacity,
	output str_state_t       nx_st,
	output logic [2:0][7:0]  nx_pend,
	output res_group_t       grp
);

	localparam logic [NEED_W-1:0] NEED_LIMIT =
		((2 * MAX_STRING_BYTES) > 32'h3FFFF) ? 18'h3FFFF : NEED_W'(2 * MAX_STRING_BYTES);

	logic [7:0]  b;
	logic        is_cont;
	logic [2:0]  lead_len;
	logic [1:0]  n1;
	logic [1:0]  n2;
	logic        main_en;
	logic        main_bad;
	logic [20:0] main_cp;
	logic [1:0]  cnt_nx;
	logic [2:0]  exp_nx;

	logic [3:0]        s_en;
	logic [3:0]        s_bad;
	logic [3:0][20:0]  s_cp;

	logic [CAP_W-1:0]  left;
	logic [NEED_W-1:0] need;
	logic [NEED_W:0]   need_sum;
	logic              nm;
	logic              ovf;
	logic [20:0]       cpx;
	logic [19:0]       vsup;
	logic              two;
	logic [2:0]        idx;
	out_beat_t [MAX_RES-1:0] res;
	logic [2:0]        last;

	assign b       = beat.in_byte;
	assign is_cont = (b[7:6] == 2'b10);

	// Sequence length announced by a lead byte, zero for a byte that cannot lead
	always_comb begin
		lead_len = 3'd0;
		if (b inside {[8'hC0:8'hDF]})
			lead_len = 3'd2;
		else if (b inside {[8'hE0:8'hEF]})
			lead_len = 3'd3;
		else if (b inside {[8'hF0:8'hF7]})
			lead_len = 3'd4;
	end

	// Sequence tracking: what gets flushed, what completes, what is buffered
	always_comb begin
		n1       = 2'd0;
		main_en  = 1'b0;
		main_bad = 1'b0;
		main_cp  = CP_REPL;
		cnt_nx   = st.pend_cnt;
		exp_nx   = st.exp_len;
		nx_pend  = pend;
		if (!st.overflow) begin
			if (st.pend_cnt != 2'd0 && is_cont) begin
				if (({1'b0, st.pend_cnt} + 3'd1) < st.exp_len) begin
					nx_pend[st.pend_cnt] = b;
					cnt_nx = st.pend_cnt + 2'd1;
				end else begin
					main_en = 1'b1;
					cnt_nx  = 2'd0;
					exp_nx  = 3'd0;
					case (st.exp_len)
						3'd2:    main_cp = {10'd0, pend[0][4:0], b[5:0]};
						3'd3:    main_cp = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
						default: main_cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
					endcase
				end
			end else begin
				n1     = st.pend_cnt;
				cnt_nx = 2'd0;
				exp_nx = 3'd0;
				if (!b[7]) begin
					main_en = 1'b1;
					main_cp = {13'd0, b};
				end else if (lead_len != 3'd0) begin
					nx_pend[0] = b;
					cnt_nx     = 2'd1;
					exp_nx     = lead_len;
				end else begin
					main_en  = 1'b1;
					main_bad = 1'b1;
				end
			end
		end
		// a truncated sequence at the end of the string is flushed too
		n2 = beat.final_byte ? cnt_nx : 2'd0;
	end

	// Order the code points to put: flushed bytes, the decoded one, the end flush
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			s_en[i]  = 1'b0;
			s_bad[i] = 1'b0;
			s_cp[i]  = CP_REPL;
			if (3'(i) < {1'b0, n1}) begin
				s_en[i]  = 1'b1;
				s_bad[i] = 1'b1;
			end else if (main_en && 3'(i) == {1'b0, n1}) begin
				s_en[i]  = 1'b1;
				s_bad[i] = main_bad;
				s_cp[i]  = main_cp;
			end else if ((3'(i) - {1'b0, n1} - {2'b0, main_en}) < {1'b0, n2}) begin
				s_en[i]  = 1'b1;
				s_bad[i] = 1'b1;
			end
		end
	end

	// Put chain: range check, capacity check, unit emission, byte count
	always_comb begin
		left     = st.units_left;
		need     = st.needed;
		nm       = st.not_mapped;
		ovf      = st.overflow;
		idx      = 3'd0;
		res      = '0;
		cpx      = CP_REPL;
		vsup     = '0;
		two      = 1'b0;
		need_sum = '0;
		for (int i = 0; i < 4; i++) begin
			if (s_en[i]) begin
				if (s_bad[i])
					nm = 1'b1;
				if (!ovf) begin
					cpx = s_cp[i];
					if (cpx > CP_MAX) begin
						cpx = CP_REPL;
						nm  = 1'b1;
					end
					two = (cpx > CP_BMP_MAX);
					if (!count_only && left < {{(CAP_W-2){1'b0}}, two, !two}) begin
						ovf = 1'b1;
					end else begin
						if (!count_only) begin
							if (two) begin
								vsup = 20'(cpx - CP_SUPP);
								res[idx[1:0]].unit_value = SURR_HI | {6'd0, vsup[19:10]};
								res[idx[1:0]].unit_valid = 1'b1;
								idx = idx + 3'd1;
								res[idx[1:0]].unit_value = SURR_LO | {6'd0, vsup[9:0]};
								res[idx[1:0]].unit_valid = 1'b1;
								idx  = idx + 3'd1;
								left = left - CAP_W'(2);
							end else begin
								res[idx[1:0]].unit_value = cpx[15:0];
								res[idx[1:0]].unit_valid = 1'b1;
								idx  = idx + 3'd1;
								left = left - CAP_W'(1);
							end
						end
						need_sum = {1'b0, need} + (two ? (NEED_W+1)'(4) : (NEED_W+1)'(2));
						need = (need_sum > {1'b0, NEED_LIMIT}) ? NEED_LIMIT : need_sum[NEED_W-1:0];
					end
				end
			end
		end
	end

	// End of string: tag the last beat and start the next string afresh
	always_comb begin
		grp.res        = res;
		grp.cnt        = idx;
		last           = 3'd0;
		nx_st.pend_cnt   = cnt_nx;
		nx_st.exp_len    = exp_nx;
		nx_st.units_left = left;
		nx_st.needed     = need;
		nx_st.not_mapped = nm;
		nx_st.overflow   = ovf;
		if (beat.final_byte) begin
			if (idx == 3'd0)
				grp.cnt = 3'd1;
			last = grp.cnt - 3'd1;
			grp.res[last[1:0]].run_end      = 1'b1;
			grp.res[last[1:0]].status       = ovf ? ST_OVERFLOW : (nm ? ST_NOT_MAPPED : ST_SUCCESS);
			grp.res[last[1:0]].needed_bytes = need;
			nx_st.pend_cnt   = 2'd0;
			nx_st.exp_len    = 3'd0;
			nx_st.units_left = capacity;
			nx_st.needed     = '0;
			nx_st.not_mapped = 1'b0;
			nx_st.overflow   = 1'b0;
		end
	end

endmodule

// File: hw/rtl/u2u_out_queue.sv
// Result register: holds the beats of one byte and hands them out one per cycle while dst_stall is low.
module u2u_out_queue import u2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_group_t grp,
	output logic       free,
	output logic       dst_valid,
	input  logic       dst_stall,
	output out_beat_t  dst_data
);

	out_beat_t [MAX_RES-1:0] q_q;
	logic [2:0]              cnt_q;
	logic                    take;

	assign dst_valid = (cnt_q != 3'd0);
	assign dst_data  = q_q[0];
	assign take      = dst_valid && !dst_stall;
	// a new group fits once the last waiting beat leaves
	assign free      = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take);

	// beat count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// beat payloads, shifted toward the head as beats leave
	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= grp.res;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				q_q[i] <= q_q[i+1];
		end
	end

endmodule

// File: hw/rtl/utf8_to_utf16_stream_unit.sv
// Top level of the UTF-8 to UTF-16 stream transcoder.
//
// Source channel: one UTF-8 byte per beat (src_data), final_byte set on the
// last byte of a string. Destination channel: one UTF-16 unit per beat; the
// last beat of a string carries run_end, status and needed_bytes. A string
// that yields no unit (count-only mode, overflow) ends with one beat whose
// unit_valid is 0.
// Configuration: cfg_index/cfg_data, always ready; written while idle.
// Index 0 sets the capacity in units and reloads the running budget;
// index 1 selects count-only mode.
// Path: a byte passes the input register and the combinational decode into the result register.
// Throughput: one byte per cycle while each byte gives at most one beat and the
// destination does not stall; a byte that gives more beats holds the source until
// the single result port has drained the result register down to its last beat.
// Reset clears all string state and the result register; capacity returns
// to 65536 units and count-only mode is off. No clearing pass is needed.
// A stall on the destination freezes the result register; the source is
// stalled once the byte in the input register cannot move on.
module utf8_to_utf16_stream_unit import u2u_pkg::*; #(
	parameter int unsigned MAX_STRING_BYTES = MAX_STR_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  in_beat_t             src_data,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output out_beat_t            dst_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data
);

	in_beat_t         data_s1;
	logic             valid_s1;
	str_state_t       st_q;
	logic [2:0][7:0]  pend_q;
	logic [CAP_W-1:0] cap_q;
	logic             count_only_q;

	str_state_t       nx_st;
	str_state_t       st_d;
	logic [2:0][7:0]  nx_pend;
	res_group_t       grp;
	logic             q_free;
	logic             advance;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// byte leaves the input register once its results fit in the result register
	assign advance   = valid_s1 && (grp.cnt == 3'd0 || q_free);
	assign src_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			data_s1 <= src_data;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			count_only_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_CAPACITY)
				cap_q <= cfg_data;
			if (cfg_index == REG_COUNT_ONLY)
				count_only_q <= cfg_data[0];
		end
	end

	// next string state; a capacity write restarts the budget
	always_comb begin
		st_d = advance ? nx_st : st_q;
		if (cfg_we && cfg_index == REG_CAPACITY)
			st_d.units_left = cfg_data;
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.pend_cnt   <= 2'd0;
			st_q.exp_len    <= 3'd0;
			st_q.units_left <= CAP_RESET;
			st_q.needed     <= '0;
			st_q.not_mapped <= 1'b0;
			st_q.overflow   <= 1'b0;
		end else begin
			st_q <= st_d;
		end
	end

	// buffered lead and continuation bytes
	always_ff @(posedge clk) begin
		if (advance)
			pend_q <= nx_pend;
	end

	u2u_decode #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_decode (
		.beat       (data_s1),
		.st         (st_q),
		.pend       (pend_q),
		.count_only (count_only_q),
		.capacity   (cap_q),
		.nx_st      (nx_st),
		.nx_pend    (nx_pend),
		.grp        (grp)
	);

	u2u_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && grp.cnt != 3'd0),
		.grp       (grp),
		.free      (q_free),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule
